// ----- hw/rtl/pes_header_timestamp_parser_defines.svh -----
// assertion macros used by the checker file
`ifndef PES_HEADER_TIMESTAMP_PARSER_DEFINES_SVH
`define PES_HEADER_TIMESTAMP_PARSER_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define PHT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pht check failed");

// next-cycle implication, quiet while reset is high
`define PHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pht check failed");

`endif

// ----- hw/rtl/pht_pkg.sv -----
package pht_pkg;

  localparam int unsigned STAMP_W  = 33;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned TDATA_W  = 80;

  localparam logic [LEN_W-1:0] LEN_MAX     = 6'd63;
  localparam logic [CNT_W-1:0] STAMP_BYTES = 4'd5;

  // header status codes
  localparam logic [1:0] ST_PTS_ONLY = 2'd0;
  localparam logic [1:0] ST_PTS_DTS  = 2'd1;
  localparam logic [1:0] ST_NO_STAMP = 2'd2;

  // flag byte high nibbles
  localparam logic [3:0] FLAG_PTS     = 4'h2;
  localparam logic [3:0] FLAG_PTS_DTS = 4'h3;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } pht_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]   header_length;
    logic [1:0]         header_status;
    logic               dts_present;
    logic               pts_present;
    logic [STAMP_W-1:0] dts_ticks;
    logic [STAMP_W-1:0] pts_ticks;
  } pht_result_t;

  // folds one timestamp byte into the accumulator, marker bits dropped
  function automatic logic [STAMP_W-1:0] take_stamp_byte(
    input logic [STAMP_W-1:0] acc,
    input logic [CNT_W-1:0]   k,
    input logic [7:0]         b
  );
    logic [STAMP_W-1:0] r;
    if (k == 4'd0) begin
      r = {30'd0, b[3:1]};
    end else if (k == 4'd1 || k == 4'd3) begin
      r = {acc[STAMP_W-9:0], b};
    end else begin
      r = {acc[STAMP_W-8:0], b[7:1]};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/pht_parse.sv -----
module pht_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  pht_pkg::pht_item_t  item,
  output logic                emit,
  output pht_pkg::pht_result_t result
);
  import pht_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEAD = 3'd1;
  localparam logic [2:0] PH_STD2 = 3'd2;
  localparam logic [2:0] PH_FLAG = 3'd3;
  localparam logic [2:0] PH_PTS  = 3'd4;
  localparam logic [2:0] PH_DTS  = 3'd5;

  logic [2:0]         phase, phase_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [STAMP_W-1:0] pts, pts_next;
  logic [STAMP_W-1:0] dts, dts_next;
  logic [LEN_W-1:0]   consumed, consumed_next;
  logic               both, both_next;

  logic [2:0]         ph_eff;
  logic [CNT_W-1:0]   cnt_eff, cnt_inc;
  logic [STAMP_W-1:0] pts_eff, dts_eff;
  logic [LEN_W-1:0]   cons_eff;
  logic               both_eff;
  logic [7:0]         b;
  logic [1:0]         status;

  always_comb begin
    b        = item.data;
    // a start byte drops whatever header was in progress
    ph_eff   = item.start ? PH_LEAD : phase;
    cnt_eff  = item.start ? '0 : count;
    pts_eff  = item.start ? '0 : pts;
    dts_eff  = item.start ? '0 : dts;
    cons_eff = item.start ? '0 : consumed;
    both_eff = item.start ? 1'b0 : both;
    cnt_inc  = cnt_eff + 4'd1;

    phase_next    = ph_eff;
    count_next    = cnt_eff;
    pts_next      = pts_eff;
    dts_next      = dts_eff;
    both_next     = both_eff;
    consumed_next = (cons_eff == LEN_MAX) ? cons_eff : cons_eff + 6'd1;
    emit          = 1'b0;
    status        = ST_NO_STAMP;

    unique case (ph_eff) inside
      PH_IDLE: begin
        consumed_next = cons_eff;
      end
      PH_LEAD, PH_FLAG: begin
        if (ph_eff == PH_LEAD && b[7]) begin
          phase_next = PH_LEAD;
        end else if (ph_eff == PH_LEAD && b[7:6] == 2'b01) begin
          phase_next = PH_STD2;
        end else if (b[7:4] == FLAG_PTS || b[7:4] == FLAG_PTS_DTS) begin
          both_next  = (b[7:4] == FLAG_PTS_DTS);
          pts_next   = take_stamp_byte('0, 4'd0, b);
          count_next = 4'd1;
          phase_next = PH_PTS;
        end else begin
          emit   = 1'b1;
          status = ST_NO_STAMP;
        end
      end
      PH_STD2: begin
        phase_next = PH_FLAG;
      end
      PH_PTS: begin
        pts_next   = take_stamp_byte(pts_eff, cnt_eff, b);
        count_next = cnt_inc;
        if (cnt_inc >= STAMP_BYTES) begin
          if (both_eff) begin
            count_next = '0;
            phase_next = PH_DTS;
          end else begin
            emit   = 1'b1;
            status = ST_PTS_ONLY;
          end
        end
      end
      PH_DTS: begin
        dts_next   = take_stamp_byte(dts_eff, cnt_eff, b);
        count_next = cnt_inc;
        if (cnt_inc >= STAMP_BYTES) begin
          emit   = 1'b1;
          status = ST_PTS_DTS;
        end
      end
      default: begin
        phase_next    = PH_IDLE;
        consumed_next = cons_eff;
      end
    endcase

    if (emit) begin
      phase_next = PH_IDLE;
      count_next = '0;
    end

    result.pts_present   = (status == ST_PTS_ONLY) || (status == ST_PTS_DTS);
    result.dts_present   = (status == ST_PTS_DTS);
    result.pts_ticks     = result.pts_present ? pts_next : '0;
    result.dts_ticks     = result.dts_present ? dts_next : '0;
    result.header_status = status;
    result.header_length = consumed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      count    <= '0;
      pts      <= '0;
      dts      <= '0;
      consumed <= '0;
      both     <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      count    <= count_next;
      pts      <= pts_next;
      dts      <= dts_next;
      consumed <= consumed_next;
      both     <= both_next;
    end
  end

endmodule

// ----- hw/rtl/pes_header_timestamp_parser.sv -----
// pes header timestamp parser, one header byte per request
// path: an accepted byte waits in the input register, is parsed as the stage steps, and its
//   result is loaded into the result register and shown on m_tvalid
// throughput: one byte per cycle when not stalled by m_tready, single parse stage in between
// reset: synchronous active-high rst empties both registers and returns the parser to idle
module pes_header_timestamp_parser (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] header_start
  // one result per completed header
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // [32:0] pts_ticks, [65:33] dts_ticks, [66] pts_present,
                                 // [67] dts_present, [69:68] header_status,
                                 // [75:70] header_length, [79:76] zero
);
  import pht_pkg::*;

  // input register
  logic        in_valid;
  pht_item_t   in_item;

  // parse stage outputs
  logic        advance;
  logic        step;
  logic        emit;
  pht_result_t result;

  // the parse stage moves whenever the result register is empty or being drained
  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  // take a new byte when the input register is empty or the held one is about to move on
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.data  <= s_tdata;
      in_item.start <= s_tuser;
    end
  end

  pht_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .emit   (emit),
    .result (result)
  );

  // result register: loaded only when a header completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && emit) begin
      m_tdata <= {4'd0, result.header_length, result.header_status, result.dts_present,
                  result.pts_present, result.dts_ticks, result.pts_ticks};
    end
  end

endmodule

// ----- hw/rtl/pht_checker.sv -----
`include "pes_header_timestamp_parser_defines.svh"

module pht_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);
  import pht_pkg::*;

  logic [1:0] st;
  logic       ptsp;
  logic       dtsp;

  assign st   = m_tdata[69:68];
  assign ptsp = m_tdata[66];
  assign dtsp = m_tdata[67];

  // a stalled result holds
  `PHT_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // presence bits follow the status code
  `PHT_ASSERT_NOW(a_flags, clk, rst, m_tvalid,
    (st != 2'd3) && (ptsp == (st == ST_PTS_ONLY || st == ST_PTS_DTS)) &&
    (dtsp == (st == ST_PTS_DTS)))

  // absent stamps read as zero
  `PHT_ASSERT_NOW(a_pts_zero, clk, rst, m_tvalid && !ptsp, m_tdata[32:0] == 33'd0)
  `PHT_ASSERT_NOW(a_dts_zero, clk, rst, m_tvalid && !dtsp, m_tdata[65:33] == 33'd0)

  // a two-stamp header spans at least ten bytes
  `PHT_ASSERT_NOW(a_dts_len, clk, rst, m_tvalid && dtsp, m_tdata[75:70] >= 6'd10)

endmodule

bind pes_header_timestamp_parser pht_checker u_pht_checker (.*);
